// ----- sv/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked property checks; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property holds at every edge outside reset.
`define ASSERT_PROP(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition never true outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)

`endif

`endif

// ----- sv/rre_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rre_pkg
// Shared types and constants of the RTT / RTO estimator.
// ---------------------------------------------------------------------------
package rre_pkg;

  localparam int SAMPLE_W  = 32;
  localparam int SLOT_FW   = 8;
  localparam int SHIFT_W   = 3;
  localparam int REG_W     = 32;
  localparam int CFG_IDX_W = 3;

  localparam int PEER_SLOTS_DEF = 256;
  localparam int TIME_BITS_DEF  = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_SHIFT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BETA_SHIFT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RTO     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RTO     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_RTO = 3'd4;

  // register reset values
  localparam logic [SHIFT_W-1:0] ALPHA_SHIFT_RST = 3'd3;
  localparam logic [SHIFT_W-1:0] BETA_SHIFT_RST  = 3'd2;
  localparam logic [REG_W-1:0]   MIN_RTO_RST     = 32'd10000;
  localparam logic [REG_W-1:0]   MAX_RTO_RST     = 32'd60000000;
  localparam logic [REG_W-1:0]   DEFAULT_RTO_RST = 32'd1000000;

  typedef struct packed {
    logic                action;
    logic [SLOT_FW-1:0]  peer_slot;
    logic [SAMPLE_W-1:0] rtt_sample_us;
  } in_t;

  typedef struct packed {
    logic [REG_W-1:0] rto_us;
    logic             estimate_valid;
  } out_t;

  // per-stage status carried along the pipeline
  typedef struct packed {
    logic vld;
    logic est;
  } stage_t;

endpackage

// ----- sv/rtt_rto_estimator.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rtt_rto_estimator
// Per-peer smoothed RTT / variance tracker returning a clamped RTO.
// ---------------------------------------------------------------------------
// Takes one request per clock while in_ready is high; each result passes
// the a, b, c and output registers, and the whole pipeline holds while
// a result waits on out_ready. The rate is set by the single
// read-modify-write of the peer table: the table read is registered and
// the previous update is bypassed into the next request, so requests to
// the same peer may follow back to back. After reset the table clears
// every slot with in_ready low; configuration writes are taken at any time.
`include "assert_macros.svh"

module rtt_rto_estimator
  import rre_pkg::*;
#(
  parameter int PEER_SLOTS = PEER_SLOTS_DEF,
  parameter int TIME_BITS  = TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_t                 out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data
);

  localparam int SLOT_W = $clog2(PEER_SLOTS);

  logic [SHIFT_W-1:0]   alpha_shift;
  logic [SHIFT_W-1:0]   beta_shift;
  logic [REG_W-1:0]     min_rto_us;
  logic [REG_W-1:0]     max_rto_us;
  logic [REG_W-1:0]     default_rto_us;

  logic                 adv;
  logic                 accept;
  logic                 busy;
  logic                 rd_en;
  logic [SLOT_W-1:0]    rd_idx;
  logic                 rd_est;
  logic [TIME_BITS-1:0] rd_sr;
  logic [TIME_BITS-1:0] rd_rv;
  logic                 wr_en;
  logic [SLOT_W-1:0]    wr_idx;
  logic [TIME_BITS-1:0] wr_sr;
  logic [TIME_BITS-1:0] wr_rv;
  stage_t               b_st;
  logic [TIME_BITS-1:0] b_sr;
  logic [TIME_BITS-1:0] b_rv;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_shift    <= ALPHA_SHIFT_RST;
      beta_shift     <= BETA_SHIFT_RST;
      min_rto_us     <= MIN_RTO_RST;
      max_rto_us     <= MAX_RTO_RST;
      default_rto_us <= DEFAULT_RTO_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ALPHA_SHIFT: alpha_shift    <= cfg_data[SHIFT_W-1:0];
        CFG_BETA_SHIFT:  beta_shift     <= cfg_data[SHIFT_W-1:0];
        CFG_MIN_RTO:     min_rto_us     <= cfg_data;
        CFG_MAX_RTO:     max_rto_us     <= cfg_data;
        CFG_DEFAULT_RTO: default_rto_us <= cfg_data;
        default: ;
      endcase
    end
  end

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv && !busy;
  assign accept   = in_valid && in_ready;

  rre_table #(
    .PEER_SLOTS (PEER_SLOTS),
    .TIME_BITS  (TIME_BITS)
  ) u_table (
    .clk    (clk),
    .rst    (rst),
    .busy   (busy),
    .rd_en  (rd_en),
    .rd_idx (rd_idx),
    .rd_est (rd_est),
    .rd_sr  (rd_sr),
    .rd_rv  (rd_rv),
    .wr_en  (wr_en),
    .wr_idx (wr_idx),
    .wr_sr  (wr_sr),
    .wr_rv  (wr_rv)
  );

  rre_update #(
    .PEER_SLOTS (PEER_SLOTS),
    .TIME_BITS  (TIME_BITS)
  ) u_update (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .accept      (accept),
    .item        (in_data),
    .alpha_shift (alpha_shift),
    .beta_shift  (beta_shift),
    .rd_en       (rd_en),
    .rd_idx      (rd_idx),
    .rd_est      (rd_est),
    .rd_sr       (rd_sr),
    .rd_rv       (rd_rv),
    .wr_en       (wr_en),
    .wr_idx      (wr_idx),
    .wr_sr       (wr_sr),
    .wr_rv       (wr_rv),
    .b_st        (b_st),
    .b_sr        (b_sr),
    .b_rv        (b_rv)
  );

  rre_timeout #(
    .TIME_BITS (TIME_BITS)
  ) u_timeout (
    .clk            (clk),
    .rst            (rst),
    .adv            (adv),
    .b_st           (b_st),
    .b_sr           (b_sr),
    .b_rv           (b_rv),
    .min_rto_us     (min_rto_us),
    .max_rto_us     (max_rto_us),
    .default_rto_us (default_rto_us),
    .out_valid      (out_valid),
    .out_data       (out_data)
  );

  // pipeline is empty when the clearing pass ends
  `ASSERT_PROP(a_empty_after_clear, clk, rst, $fell(busy) |-> !out_valid && !b_st.vld, "result pending at end of clear")

endmodule

// ----- sv/rre_table.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rre_table
// Per-peer estimate memory with registered read, write bypass and a
// clearing pass after reset.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rre_table
  import rre_pkg::*;
#(
  parameter int PEER_SLOTS = PEER_SLOTS_DEF,
  parameter int TIME_BITS  = TIME_BITS_DEF,
  localparam int SLOT_W    = $clog2(PEER_SLOTS)
) (
  input  logic                 clk,
  input  logic                 rst,
  output logic                 busy,
  input  logic                 rd_en,
  input  logic [SLOT_W-1:0]    rd_idx,
  output logic                 rd_est,
  output logic [TIME_BITS-1:0] rd_sr,
  output logic [TIME_BITS-1:0] rd_rv,
  input  logic                 wr_en,
  input  logic [SLOT_W-1:0]    wr_idx,
  input  logic [TIME_BITS-1:0] wr_sr,
  input  logic [TIME_BITS-1:0] wr_rv
);

  localparam int ENTRY_W = 2 * TIME_BITS + 1;

  logic [ENTRY_W-1:0]   mem [PEER_SLOTS];
  logic [ENTRY_W-1:0]   rd_q;
  logic [SLOT_W-1:0]    rd_idx_q;
  logic [SLOT_W-1:0]    clr_cnt;

  // last write, kept to cover a read issued at the same edge
  logic                 lw_vld;
  logic [SLOT_W-1:0]    lw_idx;
  logic [TIME_BITS-1:0] lw_sr;
  logic [TIME_BITS-1:0] lw_rv;
  logic                 hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b1;
      clr_cnt <= '0;
      lw_vld  <= 1'b0;
    end else begin
      if (busy) begin
        clr_cnt <= clr_cnt + 1'b1;
        if (clr_cnt == SLOT_W'(PEER_SLOTS - 1)) begin
          busy <= 1'b0;
        end
      end
      if (wr_en) begin
        lw_vld <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_cnt] <= '0;
    end else if (wr_en) begin
      mem[wr_idx] <= {1'b1, wr_sr, wr_rv};
    end
    if (rd_en) begin
      rd_q     <= mem[rd_idx];
      rd_idx_q <= rd_idx;
    end
    if (wr_en) begin
      lw_idx <= wr_idx;
      lw_sr  <= wr_sr;
      lw_rv  <= wr_rv;
    end
  end

  assign hit    = lw_vld && (lw_idx == rd_idx_q);
  assign rd_est = hit ? 1'b1  : rd_q[ENTRY_W-1];
  assign rd_sr  = hit ? lw_sr : rd_q[ENTRY_W-2:TIME_BITS];
  assign rd_rv  = hit ? lw_rv : rd_q[TIME_BITS-1:0];

  `ASSERT_NEVER(a_no_write_in_clear, clk, rst, busy && wr_en, "write during clearing pass")
  `ASSERT_NEVER(a_no_read_in_clear, clk, rst, busy && rd_en, "read during clearing pass")

endmodule

// ----- sv/rre_update.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rre_update
// Input register, table read request and smoothed RTT / variance update.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rre_update
  import rre_pkg::*;
#(
  parameter int PEER_SLOTS = PEER_SLOTS_DEF,
  parameter int TIME_BITS  = TIME_BITS_DEF,
  localparam int SLOT_W    = $clog2(PEER_SLOTS)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 accept,
  input  in_t                  item,
  input  logic [SHIFT_W-1:0]   alpha_shift,
  input  logic [SHIFT_W-1:0]   beta_shift,
  output logic                 rd_en,
  output logic [SLOT_W-1:0]    rd_idx,
  input  logic                 rd_est,
  input  logic [TIME_BITS-1:0] rd_sr,
  input  logic [TIME_BITS-1:0] rd_rv,
  output logic                 wr_en,
  output logic [SLOT_W-1:0]    wr_idx,
  output logic [TIME_BITS-1:0] wr_sr,
  output logic [TIME_BITS-1:0] wr_rv,
  output stage_t               b_st,
  output logic [TIME_BITS-1:0] b_sr,
  output logic [TIME_BITS-1:0] b_rv
);

  logic [TIME_BITS-1:0] samp;
  logic                 slot_ok;

  logic                 a_vld;
  logic                 a_act;
  logic                 a_ok;
  logic [SLOT_W-1:0]    a_idx;
  logic [TIME_BITS-1:0] a_samp;

  logic [TIME_BITS-1:0] diff;
  logic [TIME_BITS-1:0] sr_next;
  logic [TIME_BITS-1:0] rv_next;

  generate
    if (TIME_BITS >= SAMPLE_W) begin : g_wide
      assign samp = TIME_BITS'(item.rtt_sample_us);
    end else begin : g_sat
      assign samp = (|item.rtt_sample_us[SAMPLE_W-1:TIME_BITS]) ? '1 :
                    item.rtt_sample_us[TIME_BITS-1:0];
    end
  endgenerate

  assign slot_ok = 32'(item.peer_slot) < PEER_SLOTS;
  assign rd_en   = accept;
  assign rd_idx  = SLOT_W'(item.peer_slot);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (adv) begin
      a_vld <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_act  <= item.action;
      a_ok   <= slot_ok;
      a_idx  <= rd_idx;
      a_samp <= samp;
    end
  end

  // EWMA; variance uses the old smoothed value
  always_comb begin
    diff = (rd_sr >= a_samp) ? (rd_sr - a_samp) : (a_samp - rd_sr);
    if (rd_est) begin
      sr_next = rd_sr - (rd_sr >> alpha_shift) + (a_samp >> alpha_shift);
      rv_next = rd_rv - (rd_rv >> beta_shift) + (diff >> beta_shift);
    end else begin
      sr_next = a_samp;
      rv_next = a_samp >> 1;
    end
  end

  assign wr_en  = adv && a_vld && a_act && a_ok;
  assign wr_idx = a_idx;
  assign wr_sr  = sr_next;
  assign wr_rv  = rv_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_st.vld <= 1'b0;
    end else if (adv) begin
      b_st.vld <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_st.est <= a_ok && (a_act || rd_est);
      b_sr     <= a_act ? sr_next : rd_sr;
      b_rv     <= a_act ? rv_next : rd_rv;
    end
  end

  `ASSERT_PROP(a_fold_gives_est, clk, rst, wr_en |=> b_st.vld && b_st.est, "fold lost estimate")

endmodule

// ----- sv/rre_timeout.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rre_timeout
// Timeout from the estimate: saturated srtt + 4*rttvar, then min and max
// clamps, into the result register; the default RTO when no estimate.
// ---------------------------------------------------------------------------
module rre_timeout
  import rre_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  stage_t               b_st,
  input  logic [TIME_BITS-1:0] b_sr,
  input  logic [TIME_BITS-1:0] b_rv,
  input  logic [REG_W-1:0]     min_rto_us,
  input  logic [REG_W-1:0]     max_rto_us,
  input  logic [REG_W-1:0]     default_rto_us,
  output logic                 out_valid,
  output out_t                 out_data
);

  localparam int CW = (TIME_BITS > REG_W) ? TIME_BITS : REG_W;

  logic [TIME_BITS+2:0] sum;
  logic [TIME_BITS-1:0] sum_sat;
  stage_t               c_st;
  logic [TIME_BITS-1:0] c_rto;
  logic [CW-1:0]        rto_ext;
  logic [CW-1:0]        min_ext;
  logic [CW-1:0]        max_ext;
  logic [CW-1:0]        lo_clamp;
  logic [CW-1:0]        hi_clamp;

  assign sum     = {3'b000, b_sr} + {1'b0, b_rv, 2'b00};
  assign sum_sat = (|sum[TIME_BITS+2:TIME_BITS]) ? '1 : sum[TIME_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      c_st.vld <= 1'b0;
    end else if (adv) begin
      c_st.vld <= b_st.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_st.est <= b_st.est;
      c_rto    <= sum_sat;
    end
  end

  // max applied last, so it wins over min
  assign rto_ext  = CW'(c_rto);
  assign min_ext  = CW'(min_rto_us);
  assign max_ext  = CW'(max_rto_us);
  assign lo_clamp = (rto_ext < min_ext) ? min_ext : rto_ext;
  assign hi_clamp = (lo_clamp > max_ext) ? max_ext : lo_clamp;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= c_st.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.rto_us         <= c_st.est ? REG_W'(hi_clamp) : default_rto_us;
      out_data.estimate_valid <= c_st.est;
    end
  end

endmodule
